>>> sv/afb_pkg.sv
// afb_pkg: shared types and fixed constants for the activation forward/backward core.
// No dependencies; every file of the block but afb_fifo refers to it by scoped names.

package afb_pkg;

	localparam int DATA_W     = 16;   // Q4.12 data path
	localparam int IDX_IN_W   = 10;   // width of the element_index port
	localparam int FRAC_W     = 15;   // interpolation fraction of the scaled magnitude
	localparam int SIG_W      = 13;   // sigmoid value, 0 to 4096
	localparam int SQ_W       = 25;   // s*(4096-s), at most 2^22
	localparam int PROD_W     = 42;   // gradient times s*(4096-s)
	localparam int RND_SHIFT  = 24;

	localparam logic [SIG_W-1:0] ONE_Q12 = 13'd4096;

	// Front-to-back and result queue sizes (powers of two).
	localparam int MID_DEPTH  = 8;
	localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH  = 16;
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	// Mode register codes.
	localparam logic MODE_SIGMOID = 1'b0;
	localparam logic MODE_RELU    = 1'b1;

	// Operation codes.
	localparam logic OP_FORWARD  = 1'b0;
	localparam logic OP_BACKWARD = 1'b1;

	// Item class decided by the front end.
	typedef enum logic [1:0] {
		CLS_SIG_FWD  = 2'd0,
		CLS_SIG_BWD  = 2'd1,
		CLS_RELU_FWD = 2'd2,
		CLS_RELU_BWD = 2'd3
	} cls_t;

	// One beat of the front-to-back queue.
	typedef struct packed {
		cls_t                     cls;
		logic signed [DATA_W-1:0] x;   // forward value or cached value
		logic signed [DATA_W-1:0] g;   // gradient
	} mid_item_t;

	localparam int MID_W = $bits(mid_item_t);

endpackage

>>> sv/activation_forward_backward_core.sv
// activation_forward_backward_core: top level of the Q4.12 sigmoid/ReLU activation unit.
// Depends on afb_pkg, afb_fifo, afb_front and afb_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  input    | push / full               | operation, element_index, value, gradient
//  result   | pop / empty               | result
//  config   | cfg_valid / cfg_ready     | activation_mode
//
// One beat per cycle in and out when neither side stalls. An accepted input beat passes
// three front stages (index wrap, cache access) ending in the front-to-back queue write,
// six back stages (table, two products, rounding), and the write into the result queue
// before its result shows on the result ports.
// Reset clears the mode, all valid bits and both queues; the input cache holds no
// reset value and needs no clearing pass. A stalled result side fills the result queue,
// then the front-to-back queue, and only then raises full; each side stalls on its own.

module activation_forward_backward_core #(
	parameter int MAX_ELEMENTS          = 1024,
	parameter int SIGMOID_TABLE_ENTRIES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic [afb_pkg::IDX_IN_W-1:0]       element_index,
	input  logic signed [afb_pkg::DATA_W-1:0]  value,
	input  logic signed [afb_pkg::DATA_W-1:0]  gradient,
	// result channel
	output logic                               empty,
	input  logic                               pop,
	output logic signed [afb_pkg::DATA_W-1:0]  result,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               activation_mode
);

	logic mode_q;

	logic                           mid_push;
	logic                           mid_pop;
	logic                           mid_empty;
	logic [afb_pkg::MID_CNT_W-1:0]  mid_count;
	afb_pkg::mid_item_t             mid_wr_item;
	logic [afb_pkg::MID_W-1:0]      mid_rd_data;
	afb_pkg::mid_item_t             mid_rd_item;

	logic                           out_push;
	logic                           out_pop;
	logic [afb_pkg::OUT_CNT_W-1:0]  out_count;
	logic [afb_pkg::DATA_W-1:0]     out_wr_data;
	logic signed [afb_pkg::DATA_W-1:0] back_result;

	// Mode register: always ready; the user must write it only while the block is idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= afb_pkg::MODE_SIGMOID;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= activation_mode;
		end
	end

	// Front: accept, wrap index, touch the cache, classify.
	afb_front #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.element_index (element_index),
		.value         (value),
		.gradient      (gradient),
		.mode          (mode_q),
		.mid_count     (mid_count),
		.mid_push      (mid_push),
		.mid_item      (mid_wr_item)
	);

	// Decoupling queue between front and back.
	afb_fifo #(
		.WIDTH (afb_pkg::MID_W),
		.DEPTH (afb_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wr_item),
		.rd_en   (mid_pop),
		.rd_data (mid_rd_data),
		.count   (mid_count),
		.empty   (mid_empty)
	);

	assign mid_rd_item = mid_rd_data;

	// Back: sigmoid / ReLU forward and gradient pipeline.
	afb_back #(
		.SIGMOID_TABLE_ENTRIES (SIGMOID_TABLE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_empty  (mid_empty),
		.mid_item   (mid_rd_item),
		.mid_pop    (mid_pop),
		.out_count  (out_count),
		.out_push   (out_push),
		.out_result (back_result)
	);

	assign out_wr_data = back_result;

	// Result queue: head drives the result ports; drop it on a pop beat.
	assign out_pop = pop & ~empty;

	afb_fifo #(
		.WIDTH (afb_pkg::DATA_W),
		.DEPTH (afb_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wr_data),
		.rd_en   (out_pop),
		.rd_data (result),
		.count   (out_count),
		.empty   (empty)
	);

	// An accepted beat reaches the front-to-back queue through the front stages s1, s2 and s3.
	a_front_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> ##3 mid_push)
		else $error("accepted beat did not reach the front-to-back queue");

	// Credit keeps the front-to-back queue from overflowing.
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> (mid_count < afb_pkg::MID_DEPTH) || mid_pop)
		else $error("front-to-back queue overflow");

	// Credit keeps the result queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_count < afb_pkg::OUT_DEPTH) || out_pop)
		else $error("result queue overflow");

endmodule

>>> sv/afb_fifo.sv
// afb_fifo: small synchronous queue with occupancy count, head shown combinationally.
// Uses no package items; instantiated twice by the top level.

module afb_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(wr_en) - CW'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign count   = count_q;
	assign empty   = (count_q == '0);

endmodule

>>> sv/afb_front.sv
// afb_front: accepts items, wraps the index, owns the input cache and classifies each beat.
// Depends on afb_pkg; feeds the front-to-back queue in the top level.

module afb_front #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic [afb_pkg::IDX_IN_W-1:0]       element_index,
	input  logic signed [afb_pkg::DATA_W-1:0]  value,
	input  logic signed [afb_pkg::DATA_W-1:0]  gradient,
	input  logic                               mode,
	input  logic [afb_pkg::MID_CNT_W-1:0]      mid_count,
	output logic                               mid_push,
	output afb_pkg::mid_item_t                 mid_item
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic accept;
	logic v_s1, v_s2, v_s3;
	logic op_s1, op_s2, op_s3;
	logic [afb_pkg::IDX_IN_W-1:0]      index_s1, index_s2;
	logic signed [afb_pkg::DATA_W-1:0] value_s1, value_s2, value_s3;
	logic signed [afb_pkg::DATA_W-1:0] grad_s1, grad_s2, grad_s3;
	logic signed [afb_pkg::DATA_W-1:0] cache_rd_s3;
	logic [IDX_W-1:0]                  addr;
	logic [afb_pkg::MID_CNT_W:0]       credit_use;

	logic [afb_pkg::DATA_W-1:0] cache_q [MAX_ELEMENTS];

	// Count beats still in flight toward the queue so it can never overflow.
	assign credit_use = {1'b0, mid_count} + (afb_pkg::MID_CNT_W+1)'(v_s1)
		+ (afb_pkg::MID_CNT_W+1)'(v_s2) + (afb_pkg::MID_CNT_W+1)'(v_s3);
	assign full   = (credit_use >= (afb_pkg::MID_CNT_W+1)'(afb_pkg::MID_DEPTH));
	assign accept = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			index_s1 <= element_index;
			value_s1 <= value;
			grad_s1  <= gradient;
		end
		op_s2    <= op_s1;
		index_s2 <= index_s1;
		value_s2 <= value_s1;
		grad_s2  <= grad_s1;
		op_s3    <= op_s2;
		value_s3 <= value_s2;
		grad_s3  <= grad_s2;
	end

	// Index wrap: reciprocal quotient in stage 1, remainder in stage 2.
	if (MAX_ELEMENTS < (1 << afb_pkg::IDX_IN_W)) begin : g_wrap
		localparam logic [20:0] RECIP = 21'(((1 << 20) + MAX_ELEMENTS - 1) / MAX_ELEMENTS);
		logic [30:0] recip_prod;
		logic [9:0]  quot_s2;
		logic [19:0] quot_mul;
		logic [19:0] rem;

		assign recip_prod = 31'(index_s1) * 31'(RECIP);

		always_ff @(posedge clk) begin
			quot_s2 <= recip_prod[29:20];
		end

		assign quot_mul = 20'(quot_s2) * 20'(MAX_ELEMENTS);
		assign rem      = 20'(index_s2) - quot_mul;
		assign addr     = rem[IDX_W-1:0];
	end else begin : g_nowrap
		assign addr = IDX_W'(index_s2);
	end

	// Input cache: forward beats write, backward beats read.
	always_ff @(posedge clk) begin
		if (v_s2 && op_s2 == afb_pkg::OP_FORWARD) begin
			cache_q[addr] <= value_s2;
		end
		cache_rd_s3 <= cache_q[addr];
	end

	always_comb begin
		mid_item.g = grad_s3;
		mid_item.x = (op_s3 == afb_pkg::OP_BACKWARD) ? cache_rd_s3 : value_s3;
		if (mode == afb_pkg::MODE_RELU) begin
			mid_item.cls = (op_s3 == afb_pkg::OP_BACKWARD) ? afb_pkg::CLS_RELU_BWD
				: afb_pkg::CLS_RELU_FWD;
		end else begin
			mid_item.cls = (op_s3 == afb_pkg::OP_BACKWARD) ? afb_pkg::CLS_SIG_BWD
				: afb_pkg::CLS_SIG_FWD;
		end
	end

	assign mid_push = v_s3;

endmodule

>>> sv/afb_back.sv
// afb_back: six-stage pipeline for sigmoid interpolation, ReLU and gradient products.
// Depends on afb_pkg; pops the front-to-back queue and pushes the result queue.

module afb_back #(
	parameter int SIGMOID_TABLE_ENTRIES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               mid_empty,
	input  afb_pkg::mid_item_t                 mid_item,
	output logic                               mid_pop,
	input  logic [afb_pkg::OUT_CNT_W-1:0]      out_count,
	output logic                               out_push,
	output logic signed [afb_pkg::DATA_W-1:0]  out_result
);

	localparam int KW  = $clog2(SIGMOID_TABLE_ENTRIES);
	localparam int P_W = afb_pkg::FRAC_W + $clog2(SIGMOID_TABLE_ENTRIES + 1);
	localparam int DW  = afb_pkg::DATA_W;
	localparam int SW  = afb_pkg::SIG_W;

	// Shift-subtract quotient; only evaluated while the tables are built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo, rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry i = round(4096 / (1 + exp(-8*i/N))), fixed-point exp built by series and squaring.
	function automatic logic [15:0] sig_entry(input int unsigned i);
		logic [63:0] y, term, sum, s, a, e, c;
		logic        done;
		y    = udiv64(64'(i) << 28, 64'(SIGMOID_TABLE_ENTRIES));
		sum  = 64'd1 << 28;
		term = 64'd1 << 28;
		done = 1'b0;
		for (int k = 1; k <= 30; k++) begin
			if (!done) begin
				term = udiv64((term * y) >> 28, 64'(k));
				if (term == 64'd0) begin
					done = 1'b1;
				end else begin
					sum = sum + term;
				end
			end
		end
		s = (sum * sum + (64'd1 << 27)) >> 28;
		s = (s * s + (64'd1 << 27)) >> 28;
		a = (s + 64'd128) >> 8;
		e = (a * a + (64'd1 << 19)) >> 20;
		c = 64'd1 << 20;
		return 16'(udiv64(64'd4096 * e + ((e + c) >> 1), e + c));
	endfunction

	logic [15:0] lo_tab   [SIGMOID_TABLE_ENTRIES];
	logic [15:0] diff_tab [SIGMOID_TABLE_ENTRIES];

	// Constant tables: segment base and slope, a negative slope counts as zero.
	for (genvar gi = 0; gi < SIGMOID_TABLE_ENTRIES; gi++) begin : g_tab
		localparam logic [15:0] LO = sig_entry(gi);
		localparam logic [15:0] HI = sig_entry(gi + 1);
		assign lo_tab[gi]   = LO;
		assign diff_tab[gi] = (HI > LO) ? HI - LO : 16'd0;
	end

	// Valid chain and payload per stage.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	afb_pkg::cls_t cls_s1, cls_s2, cls_s3, cls_s4, cls_s5, cls_s6;
	logic signed [DW-1:0] x_s1;
	logic signed [DW-1:0] g_s1, g_s2, g_s3, g_s4, g_s5;
	logic signed [DW-1:0] rl_s2, rl_s3, rl_s4, rl_s5, rl_s6;
	logic        neg_s2, neg_s3;
	logic [15:0] lo_s2, lo_s3, diff_s2;
	logic [afb_pkg::FRAC_W-1:0] frac_s2;
	logic [31:0] dprod_s3;
	logic [SW-1:0] sig_s4, sig_s5, sig_s6;
	logic [afb_pkg::SQ_W-1:0] sq_s5;
	logic signed [afb_pkg::PROD_W-1:0] gprod_s6;

	logic [afb_pkg::OUT_CNT_W:0] credit_use;
	logic [afb_pkg::FRAC_W-1:0]  mag;
	logic [P_W-1:0]              scaled;
	logic [KW-1:0]               seg;
	logic signed [DW-1:0]        relu_val;
	logic [31:0]                 interp;
	logic [SW-1:0]               s_abs;
	logic [SW-1:0]               sig_val;
	logic [afb_pkg::PROD_W-1:0]  rnd_sum;
	logic signed [afb_pkg::PROD_W-1:0] rnd_shift;

	// Pop only when the result queue has room for everything in the pipeline.
	assign credit_use = {1'b0, out_count} + (afb_pkg::OUT_CNT_W+1)'(v_s1)
		+ (afb_pkg::OUT_CNT_W+1)'(v_s2) + (afb_pkg::OUT_CNT_W+1)'(v_s3)
		+ (afb_pkg::OUT_CNT_W+1)'(v_s4) + (afb_pkg::OUT_CNT_W+1)'(v_s5)
		+ (afb_pkg::OUT_CNT_W+1)'(v_s6);
	assign mid_pop = ~mid_empty
		& (credit_use < (afb_pkg::OUT_CNT_W+1)'(afb_pkg::OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: magnitude, table segment and ReLU result.
	always_comb begin
		if (x_s1 == 16'sh8000) begin
			mag = '1;
		end else if (x_s1[DW-1]) begin
			mag = afb_pkg::FRAC_W'(-x_s1);
		end else begin
			mag = afb_pkg::FRAC_W'(x_s1);
		end
		scaled = P_W'(mag) * P_W'(SIGMOID_TABLE_ENTRIES);
		seg    = scaled[afb_pkg::FRAC_W +: KW];
		if (cls_s1 == afb_pkg::CLS_RELU_BWD) begin
			relu_val = (x_s1 > 16'sd0) ? g_s1 : 16'sd0;
		end else begin
			relu_val = (x_s1 > 16'sd0) ? x_s1 : 16'sd0;
		end
	end

	// Stage 3: interpolate and mirror negative inputs.
	always_comb begin
		interp  = (dprod_s3 + 32'd16384) >> 15;
		s_abs   = SW'(32'(lo_s3) + interp);
		sig_val = neg_s3 ? afb_pkg::ONE_Q12 - s_abs : s_abs;
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			cls_s1 <= mid_item.cls;
			x_s1   <= mid_item.x;
			g_s1   <= mid_item.g;
		end
		cls_s2   <= cls_s1;
		g_s2     <= g_s1;
		rl_s2    <= relu_val;
		neg_s2   <= x_s1[DW-1];
		lo_s2    <= lo_tab[seg];
		diff_s2  <= diff_tab[seg];
		frac_s2  <= scaled[afb_pkg::FRAC_W-1:0];

		cls_s3   <= cls_s2;
		g_s3     <= g_s2;
		rl_s3    <= rl_s2;
		neg_s3   <= neg_s2;
		lo_s3    <= lo_s2;
		dprod_s3 <= 32'(diff_s2) * 32'(frac_s2);

		cls_s4   <= cls_s3;
		g_s4     <= g_s3;
		rl_s4    <= rl_s3;
		sig_s4   <= sig_val;

		cls_s5   <= cls_s4;
		g_s5     <= g_s4;
		rl_s5    <= rl_s4;
		sig_s5   <= sig_s4;
		sq_s5    <= afb_pkg::SQ_W'(sig_s4) * afb_pkg::SQ_W'(afb_pkg::ONE_Q12 - sig_s4);

		cls_s6   <= cls_s5;
		rl_s6    <= rl_s5;
		sig_s6   <= sig_s5;
		gprod_s6 <= afb_pkg::PROD_W'(g_s5) * $signed({17'd0, sq_s5});
	end

	// Stage 6: round half up at bit 24, saturate, select by class.
	always_comb begin
		rnd_sum   = afb_pkg::PROD_W'(gprod_s6) + (afb_pkg::PROD_W'(1) << (afb_pkg::RND_SHIFT - 1));
		rnd_shift = $signed(rnd_sum) >>> afb_pkg::RND_SHIFT;
		case (cls_s6)
			afb_pkg::CLS_SIG_FWD: begin
				out_result = DW'(sig_s6);
			end
			afb_pkg::CLS_SIG_BWD: begin
				if (rnd_shift > afb_pkg::PROD_W'(32767)) begin
					out_result = 16'sh7fff;
				end else if (rnd_shift < -afb_pkg::PROD_W'(32768)) begin
					out_result = 16'sh8000;
				end else begin
					out_result = rnd_shift[DW-1:0];
				end
			end
			afb_pkg::CLS_RELU_FWD, afb_pkg::CLS_RELU_BWD: begin
				out_result = rl_s6;
			end
			default: begin
				out_result = rl_s6;
			end
		endcase
	end

	assign out_push = v_s6;

endmodule

>>> dv/afb_activation_checker.sv
// afb_activation_checker: watches the input, result and mode channels of the activation core,
// predicts every result and compares it with what the core returns. Depends on afb_pkg.

module afb_activation_checker #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LUT_N        = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               full,
	input  logic                               operation,
	input  logic [afb_pkg::IDX_IN_W-1:0]       element_index,
	input  logic signed [afb_pkg::DATA_W-1:0]  value,
	input  logic signed [afb_pkg::DATA_W-1:0]  gradient,
	input  logic                               empty,
	input  logic                               pop,
	input  logic signed [afb_pkg::DATA_W-1:0]  result,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic                               activation_mode,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [afb_pkg::DATA_W-1:0]        sig_lut [0:LUT_N];
	logic [afb_pkg::DATA_W-1:0]        x_cache [0:MAX_ELEMENTS-1];
	logic                              mode_q;
	logic signed [afb_pkg::DATA_W-1:0] expected_q [$];

	// Sigmoid table: Taylor series of exp(i/N) in Q28, squared up to exp(8i/N).
	initial begin
		longint unsigned y, sum, term, sq, a, e, c;
		fail_count = 0;
		checked    = 0;
		pending    = 0;
		for (int i = 0; i <= LUT_N; i++) begin
			y    = (longint'(i) << 28) / LUT_N;
			sum  = 64'd1 << 28;
			term = sum;
			for (int k = 1; k <= 30; k++) begin
				term = ((term * y) >> 28) / k;
				if (term == 0)
					break;
				sum += term;
			end
			sq = (sum * sum + (64'd1 << 27)) >> 28;
			sq = (sq * sq + (64'd1 << 27)) >> 28;
			a  = (sq + 128) >> 8;
			e  = (a * a + (64'd1 << 19)) >> 20;
			c  = 64'd1 << 20;
			sig_lut[i] = (4096 * e + (e + c) / 2) / (e + c);
		end
	end

	function automatic logic [afb_pkg::SIG_W-1:0] sigmoid_q12(
			logic signed [afb_pkg::DATA_W-1:0] x);
		int mag, scaled, k, f, lo, hi, diff, s;
		mag = (x < 0) ? -int'(x) : int'(x);
		if (mag > 32767)
			mag = 32767;
		scaled = mag * LUT_N;
		k      = scaled >> afb_pkg::FRAC_W;
		f      = scaled & 32'h7fff;
		lo     = sig_lut[k];
		hi     = sig_lut[k+1];
		diff   = (hi > lo) ? hi - lo : 0;
		s      = lo + ((diff * f + 16384) >> afb_pkg::FRAC_W);
		if (x < 0)
			s = int'(afb_pkg::ONE_Q12) - s;
		return s[afb_pkg::SIG_W-1:0];
	endfunction

	function automatic logic signed [afb_pkg::DATA_W-1:0] forward_out(logic mode,
			logic signed [afb_pkg::DATA_W-1:0] x);
		if (mode == afb_pkg::MODE_RELU)
			return (x > 0) ? x : '0;
		return {{(afb_pkg::DATA_W-afb_pkg::SIG_W){1'b0}}, sigmoid_q12(x)};
	endfunction

	function automatic logic signed [afb_pkg::DATA_W-1:0] backward_out(logic mode,
			logic signed [afb_pkg::DATA_W-1:0] cx, logic signed [afb_pkg::DATA_W-1:0] g);
		logic [afb_pkg::SIG_W-1:0] s;
		longint                    prod, r;
		if (mode == afb_pkg::MODE_RELU)
			return (cx > 0) ? g : '0;
		s    = sigmoid_q12(cx);
		prod = longint'(g) * longint'(s) * (longint'(afb_pkg::ONE_Q12) - longint'(s));
		// round half up, then clamp to 16 bits
		r = (prod + (longint'(1) <<< (afb_pkg::RND_SHIFT - 1))) >>> afb_pkg::RND_SHIFT;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[afb_pkg::DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [afb_pkg::DATA_W-1:0] want;
		int unsigned                       idx;
		if (!arst_n) begin
			mode_q = afb_pkg::MODE_SIGMOID;
			expected_q.delete();
			pending = 0;
		end else begin
			// results first: a result beat always belongs to an older input beat
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no expected value: actual %0d", result);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (result !== want) begin
						$error("result mismatch: expected %0d, actual %0d", want, result);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				mode_q = activation_mode;
			if (push && !full) begin
				idx = element_index % MAX_ELEMENTS;
				if (operation == afb_pkg::OP_FORWARD) begin
					x_cache[idx] = value;
					expected_q.push_back(forward_out(mode_q, value));
				end else begin
					expected_q.push_back(backward_out(mode_q, x_cache[idx], gradient));
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> dv/tb_activation_forward_backward_core.sv
// tb_activation_forward_backward_core: stimulus and verdict for the activation core.
// Depends on afb_pkg, activation_forward_backward_core and afb_activation_checker.

module tb_activation_forward_backward_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ELEM   = 1024;
	localparam int PIPE_LAT   = 11;
	localparam int PHASE_LEN  = 135;

	logic                              clk;
	logic                              arst_n;
	logic                              push;
	logic                              full;
	logic                              operation;
	logic [afb_pkg::IDX_IN_W-1:0]      element_index;
	logic signed [afb_pkg::DATA_W-1:0] value;
	logic signed [afb_pkg::DATA_W-1:0] gradient;
	logic                              empty;
	logic                              pop;
	logic signed [afb_pkg::DATA_W-1:0] result;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic                              activation_mode;

	int fail_count, pending, checked;
	int fwd_beats, bwd_beats, mode_writes;

	// Track which cache entries hold a value, so a backward beat never reads a blank one.
	bit idx_written [0:NUM_ELEM-1];
	int written_list [$];

	// When set, the matching side runs with no idle cycles.
	bit source_free, sink_free;

	activation_forward_backward_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.operation       (operation),
		.element_index   (element_index),
		.value           (value),
		.gradient        (gradient),
		.empty           (empty),
		.pop             (pop),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.activation_mode (activation_mode)
	);

	afb_activation_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.operation       (operation),
		.element_index   (element_index),
		.value           (value),
		.gradient        (gradient),
		.empty           (empty),
		.pop             (pop),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.activation_mode (activation_mode),
		.fail_count      (fail_count),
		.pending         (pending),
		.checked         (checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none, often a few cycles, now and then long enough
	// to back up both internal queues.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Q4.12 operand: full range, the useful sigmoid span, extremes, and values near saturation.
	function automatic logic signed [afb_pkg::DATA_W-1:0] rand_q12();
		logic signed [afb_pkg::DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1, 2: v = $urandom;
			3, 4:    v = $urandom_range(0, 18000) - 9000;
			5: begin
				case ($urandom_range(0, 4))
					0:       v = 16'sh7fff;
					1:       v = 16'sh8000;
					2:       v = 16'sh0000;
					3:       v = 16'sh0001;
					default: v = 16'shffff;
				endcase
			end
			default: begin
				v = 32767 - $urandom_range(0, 600);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Result side: pop with random stalls unless told to run free.
	initial begin
		int stall;
		stall = 0;
		pop   = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (!sink_free)
					stall = pick_gap();
			end
		end
	end

	// Present one input beat and hold it until the core takes it.
	task automatic send_item(logic op, logic [afb_pkg::IDX_IN_W-1:0] idx,
			logic signed [afb_pkg::DATA_W-1:0] x, logic signed [afb_pkg::DATA_W-1:0] g);
		int gap;
		gap = source_free ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push          <= 1'b1;
		operation     <= op;
		element_index <= idx;
		value         <= x;
		gradient      <= g;
		do
			@(posedge clk);
		while (full);
		if (op == afb_pkg::OP_FORWARD) begin
			fwd_beats++;
			if (!idx_written[idx]) begin
				idx_written[idx] = 1'b1;
				written_list.push_back(idx);
			end
		end else begin
			bwd_beats++;
		end
	endtask

	// Drop push and hold off until every expected result is back.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		wait (pending == 0);
	endtask

	// Mode write; only called with the core idle.
	task automatic write_mode(logic m);
		@(negedge clk);
		cfg_valid       <= 1'b1;
		activation_mode <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		mode_writes++;
	endtask

	// Random beat: backward on a cached index about 45% of the time, otherwise
	// forward, half the time into a small hot set so entries get overwritten and reread.
	task automatic random_item();
		logic [afb_pkg::IDX_IN_W-1:0] idx;
		if (written_list.size() > 0 && $urandom_range(0, 99) < 45) begin
			idx = written_list[$urandom_range(0, written_list.size() - 1)];
			send_item(afb_pkg::OP_BACKWARD, idx, rand_q12(), rand_q12());
		end else begin
			idx = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, NUM_ELEM - 1);
			send_item(afb_pkg::OP_FORWARD, idx, rand_q12(), rand_q12());
		end
	endtask

	task automatic random_phase(logic m, bit quiet, bit hold_mid);
		drain();
		write_mode(m);
		source_free = quiet;
		sink_free   = quiet;
		for (int i = 0; i < PHASE_LEN; i++) begin
			// pause the source once mid-phase until the core has emptied
			if (hold_mid && i == PHASE_LEN / 2)
				drain();
			random_item();
		end
		source_free = 1'b0;
		sink_free   = 1'b0;
	endtask

	initial begin
		push            = 1'b0;
		operation       = afb_pkg::OP_FORWARD;
		element_index   = '0;
		value           = '0;
		gradient        = '0;
		cfg_valid       = 1'b0;
		activation_mode = afb_pkg::MODE_SIGMOID;
		source_free     = 1'b0;
		sink_free       = 1'b0;
		fwd_beats       = 0;
		bwd_beats       = 0;
		mode_writes     = 0;
		arst_n          = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sigmoid after reset: zero, both saturated ends, one LSB either way,
		// plus and minus one, table step boundaries, top table entry.
		send_item(afb_pkg::OP_FORWARD, 10'd0,    16'sh0000, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd1,    16'sh7fff, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd2,    16'sh8000, 16'sh7fff);
		send_item(afb_pkg::OP_FORWARD, 10'd3,    16'sh0001, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd4,    16'shffff, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd5,    16'sh1000, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd6,    -16'sh1000, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd1023, 16'sh007f, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd7,    16'sh0080, 16'sh0000);
		// Backward: extreme gradients, and half-LSB ties at x = 0 that round upward.
		send_item(afb_pkg::OP_BACKWARD, 10'd1,    16'sh0000, 16'sh7fff);
		send_item(afb_pkg::OP_BACKWARD, 10'd2,    16'sh0000, 16'sh8000);
		send_item(afb_pkg::OP_BACKWARD, 10'd0,    16'sh0000, 16'sh0002);
		send_item(afb_pkg::OP_BACKWARD, 10'd0,    16'sh0000, -16'sh0002);
		send_item(afb_pkg::OP_BACKWARD, 10'd5,    16'sh0000, 16'sh7fff);
		send_item(afb_pkg::OP_BACKWARD, 10'd1023, 16'sh0000, 16'sh8000);

		// ReLU: zero, one LSB either way, both ends; backward on positive, zero and
		// negative cache entries, including ones written under sigmoid.
		drain();
		write_mode(afb_pkg::MODE_RELU);
		send_item(afb_pkg::OP_FORWARD, 10'd8,  16'sh0000, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd9,  16'sh0001, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd10, 16'shffff, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd11, 16'sh7fff, 16'sh0000);
		send_item(afb_pkg::OP_FORWARD, 10'd12, 16'sh8000, 16'sh0000);
		send_item(afb_pkg::OP_BACKWARD, 10'd9,  16'sh0000, 16'sh8000);
		send_item(afb_pkg::OP_BACKWARD, 10'd10, 16'sh0000, 16'sh7fff);
		send_item(afb_pkg::OP_BACKWARD, 10'd8,  16'sh0000, 16'sh3039);
		send_item(afb_pkg::OP_BACKWARD, 10'd1,  16'sh0000, 16'sh8000);
		send_item(afb_pkg::OP_BACKWARD, 10'd2,  16'sh0000, 16'sh0001);

		// Random phases alternate the mode; the second runs with no idling at all,
		// the third holds the source until the core drains.
		random_phase(afb_pkg::MODE_SIGMOID, 1'b0, 1'b0);
		random_phase(afb_pkg::MODE_RELU,    1'b1, 1'b0);
		random_phase(afb_pkg::MODE_SIGMOID, 1'b0, 1'b1);
		random_phase(afb_pkg::MODE_RELU,    1'b0, 1'b0);

		// Let the tail drain, then watch for stray beats a while longer.
		drain();
		repeat (3 * PIPE_LAT) @(posedge clk);

		$display("Covered %0d forward and %0d backward beats across %0d mode writes;",
			fwd_beats, bwd_beats, mode_writes);
		$display("%0d results compared, %0d cache entries written.",
			checked, written_list.size());
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
